[sv/uvss_pkg.sv]
// Package for the unit vector slew smoother: fixed-point widths, command codes
// and the direction vector type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package uvss_pkg;
  // Fraction bits of a direction component (Q2.30).
  localparam int FRAC_BITS = 30;
  // Direction component width: sign, integer bit, fraction.
  localparam int DIR_W = FRAC_BITS + 2;
  // Width of the external words.
  localparam int WORD_W = 32;
  // Weighted sum 31*cur + des reaches 2^(FRAC_BITS+5) in magnitude.
  localparam int SUM_W = DIR_W + 5;
  localparam int MAG_W = SUM_W - 1;
  localparam int SLEW_SHIFT = 5;
  // Magnitudes are aligned so the largest lies in [2^29, 2^30).
  localparam int ALIGN_BIT = 29;
  localparam int SQ_W = 2 * ALIGN_BIT + 2;
  localparam int ROOT_W = 64;
  localparam int R_W = 32;
  localparam int QUO_W = FRAC_BITS + 1;
  localparam int CNT_W = 6;
  localparam int SQRT_STEPS = 32;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_GOTO = 1'b1;

  typedef logic signed [DIR_W-1:0] dir_t;
  localparam dir_t DIR_ONE = dir_t'(1) <<< FRAC_BITS;
endpackage
`default_nettype wire

[sv/unit_vector_slew_smoother.sv]
// Top level of the unit vector slew smoother: one sequencer around a shared
// shifter, multiplier, square-root step and divide step. Uses uvss_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Pointing smoother for a simulated mount. The pointing direction is a unit
// vector in signed Q2.30. A goto word (cmd = 1) normalizes its target vector
// and stores it as the desired direction; a zero target leaves it unchanged.
// A tick word (cmd = 0) forms 31 * current + desired, renormalizes it to unit
// length and makes it the current direction; if that sum is zero, the current
// direction jumps to the desired one. Every word returns one result word with
// the current direction. Rounding truncates toward zero everywhere.
// Timing: one word is worked on at a time and in_stall is high while it is.
// The next word can be taken in the cycle after the result is loaded. The
// steps are: take sign and magnitude; shift the magnitudes one bit per cycle
// (up to 29 bits) until aligned, then see the alignment; form the sum of
// squares on the single multiplier; take the bitwise square root; divide each
// component by restoring division sharing one subtractor; then load the
// output register. A zero vector skips the arithmetic.
// The output register lets the next word be accepted while a result still
// waits under out_stall; only the load of the following result waits for it.
module unit_vector_slew_smoother import uvss_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     cmd,
  input  wire logic signed [WORD_W-1:0] target_x,
  input  wire logic signed [WORD_W-1:0] target_y,
  input  wire logic signed [WORD_W-1:0] target_z,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [WORD_W-1:0]      pos_x,
  output logic signed [WORD_W-1:0]      pos_y,
  output logic signed [WORD_W-1:0]      pos_z
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ABS   = 3'd1;
  localparam logic [2:0] ST_ALIGN = 3'd2;
  localparam logic [2:0] ST_SQ    = 3'd3;
  localparam logic [2:0] ST_SQRT  = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0] state;
  logic       is_goto;
  logic [CNT_W-1:0] cnt;
  logic [1:0] idx;

  dir_t cur [3];
  dir_t des [3];
  dir_t res [3];

  logic signed [SUM_W-1:0] vec [3];
  logic [MAG_W-1:0] mag [3];
  logic neg [3];

  logic [SQ_W-1:0]   prod;
  logic [ROOT_W-1:0] acc;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W-1:0] bitv;
  logic [R_W-1:0]    rem;
  logic [QUO_W-1:0]  quo;

  logic accept_in;
  logic out_load;
  logic any_high, any_mid, all_zero;
  logic [ALIGN_BIT:0] mag_sel;
  logic neg_sel;
  logic [ROOT_W-1:0] sq_try;
  logic [R_W:0] trial;
  logic trial_ge;
  logic [R_W:0] trial_sub;
  dir_t quo_signed;

  assign in_stall  = (state != ST_IDLE);
  assign accept_in = in_valid && !in_stall;
  // Load the output register once it is free.
  assign out_load  = (state == ST_OUT) && (!out_valid || !out_stall);

  // Alignment tests: any magnitude at or above 2^30, or at or above 2^29.
  always_comb begin
    any_high = 1'b0;
    any_mid  = 1'b0;
    all_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      any_high = any_high | (|mag[i][MAG_W-1:ALIGN_BIT+1]);
      any_mid  = any_mid  | (|mag[i][MAG_W-1:ALIGN_BIT]);
      all_zero = all_zero & (mag[i] == '0);
    end
  end

  // Select the component that the multiplier or divider works on.
  always_comb begin
    unique case (idx)
      2'd0:    begin mag_sel = mag[0][ALIGN_BIT:0]; neg_sel = neg[0]; end
      2'd1:    begin mag_sel = mag[1][ALIGN_BIT:0]; neg_sel = neg[1]; end
      2'd2:    begin mag_sel = mag[2][ALIGN_BIT:0]; neg_sel = neg[2]; end
      default: begin mag_sel = '0;                  neg_sel = 1'b0;   end
    endcase
  end

  // Square-root and restoring-division steps.
  assign sq_try    = root + bitv;
  assign trial     = (cnt == '0) ? (R_W+1)'(mag_sel) : {rem, 1'b0};
  assign trial_ge  = trial >= {1'b0, root[R_W-1:0]};
  assign trial_sub = trial - {1'b0, root[R_W-1:0]};
  assign quo_signed = neg_sel ? -dir_t'({quo[QUO_W-2:0], trial_ge})
                              : dir_t'({quo[QUO_W-2:0], trial_ge});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cur[0] <= DIR_ONE; cur[1] <= '0; cur[2] <= '0;
      des[0] <= DIR_ONE; des[1] <= '0; des[2] <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept_in) begin
            is_goto <= (cmd == CMD_GOTO);
            // Latch the vector to normalize: target, or 31 * cur + des.
            if (cmd == CMD_GOTO) begin
              vec[0] <= SUM_W'(target_x);
              vec[1] <= SUM_W'(target_y);
              vec[2] <= SUM_W'(target_z);
            end else begin
              for (int i = 0; i < 3; i++) begin
                vec[i] <= (SUM_W'(cur[i]) <<< SLEW_SHIFT) - SUM_W'(cur[i])
                          + SUM_W'(des[i]);
              end
            end
            state <= ST_ABS;
          end
        end
        ST_ABS: begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= vec[i] < 0;
            mag[i] <= MAG_W'((vec[i] < 0) ? -vec[i] : vec[i]);
          end
          state <= ST_ALIGN;
        end
        ST_ALIGN: begin
          // Shift all magnitudes one bit a cycle until aligned; an all-zero vector goes straight to output.
          if (all_zero) begin
            if (!is_goto) begin
              for (int i = 0; i < 3; i++) cur[i] <= des[i];
            end
            state <= ST_OUT;
          end else if (any_high) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else if (!any_mid) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else begin
            idx   <= 2'd0;
            cnt   <= '0;
            acc   <= '0;
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          // Multiply one component a cycle, accumulate the product after.
          prod <= SQ_W'(mag_sel) * SQ_W'(mag_sel);
          if (cnt != '0) begin
            acc <= acc + ROOT_W'(prod);
          end
          idx <= idx + 2'd1;
          if (cnt == CNT_W'(3)) begin
            root  <= '0;
            bitv  <= ROOT_W'(1) << (ROOT_W - 2);
            cnt   <= '0;
            state <= ST_SQRT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_SQRT: begin
          if (acc >= sq_try) begin
            acc  <= acc - sq_try;
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
          if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
            cnt   <= '0;
            idx   <= 2'd0;
            quo   <= '0;
            state <= ST_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIV: begin
          // One quotient bit a cycle; the first step yields the integer bit.
          rem <= trial_ge ? trial_sub[R_W-1:0] : trial[R_W-1:0];
          if (cnt == CNT_W'(FRAC_BITS)) begin
            res[idx] <= quo_signed;
            cnt <= '0;
            quo <= '0;
            idx <= idx + 2'd1;
            if (idx == 2'd2) begin
              for (int i = 0; i < 2; i++) begin
                if (is_goto) des[i] <= res[i];
                else         cur[i] <= res[i];
              end
              if (is_goto) des[2] <= quo_signed;
              else         cur[2] <= quo_signed;
              state <= ST_OUT;
            end
          end else begin
            quo <= {quo[QUO_W-2:0], trial_ge};
            cnt <= cnt + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            pos_x <= WORD_W'(cur[0]);
            pos_y <= WORD_W'(cur[1]);
            pos_z <= WORD_W'(cur[2]);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[sv/uvss_checker.sv]
// Port-level checks for the unit vector slew smoother, and the bind that
// attaches them. Uses uvss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module uvss_checker import uvss_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic signed [WORD_W-1:0] pos_x,
  input wire logic signed [WORD_W-1:0] pos_y,
  input wire logic signed [WORD_W-1:0] pos_z
);
  // A word in flight blocks the input side on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepting a word");

  // A new result only appears at the end of work on a word.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a word in flight");

  // Components of a unit vector stay within [-1.0, 1.0].
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pos_x <= WORD_W'(DIR_ONE)) && (pos_x >= -WORD_W'(DIR_ONE))
      && (pos_y <= WORD_W'(DIR_ONE)) && (pos_y >= -WORD_W'(DIR_ONE))
      && (pos_z <= WORD_W'(DIR_ONE)) && (pos_z >= -WORD_W'(DIR_ONE)))
    else $error("result component outside unit range");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(pos_y)
      && $stable(pos_z))
    else $error("stalled result changed");
endmodule

bind unit_vector_slew_smoother uvss_checker u_uvss_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z)
);
`default_nettype wire
